@@ hdl/led64_block_encrypt_core_macros.svh @@
// assertion macros for the led64 block encrypt core
// used by the top level; expects clk_i and rst_ni in scope
`ifndef LED64_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define LED64_BLOCK_ENCRYPT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LED64_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("led64 assertion failed");
`define LED64_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("led64 reset assertion failed");
`else
`define LED64_ASSERT(lbl, prop)
`define LED64_ASSERT_RST(lbl, prop)
`endif
`endif

@@ hdl/led64_pkg.sv @@
// shared types, tables and round function for the led64 cipher core
// no dependencies
package led64_pkg;

  localparam int unsigned NumRounds    = 32;
  localparam int unsigned RoundsPerKey = 4;
  localparam int unsigned NumNibbles   = 16;

  typedef logic [3:0]  nibble_t;
  typedef logic [63:0] block_t;
  typedef logic [5:0]  rc_t;

  typedef struct packed {
    logic   valid;
    block_t data;
  } stage_t;

  localparam logic [3:0] GfPoly = 4'h3;

  localparam nibble_t Sbox [NumNibbles] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  localparam nibble_t MixMatrix [4][4] = '{
    '{4'h4, 4'h1, 4'h2, 4'h2},
    '{4'h8, 4'h6, 4'h5, 4'h6},
    '{4'hB, 4'hE, 4'hA, 4'h9},
    '{4'h2, 4'h2, 4'hF, 4'hB}
  };

  // key-size nibble xored with row index
  localparam nibble_t AddConstCol0 [4] = '{4'h4, 4'h5, 4'h2, 4'h3};

  localparam rc_t RoundConst [NumRounds] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B,
    6'h37, 6'h2F, 6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E,
    6'h1D, 6'h3A, 6'h35, 6'h2B, 6'h16, 6'h2C, 6'h18, 6'h30,
    6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E, 6'h1C, 6'h38
  };

  function automatic nibble_t gf_xtime(nibble_t a);
    gf_xtime = a[3] ? ({a[2:0], 1'b0} ^ GfPoly) : {a[2:0], 1'b0};
  endfunction

  function automatic nibble_t gf_mul(nibble_t a, nibble_t b);
    nibble_t acc;
    nibble_t p;
    acc = '0;
    p   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        acc = acc ^ p;
      end
      p = gf_xtime(p);
    end
    gf_mul = acc;
  endfunction

  function automatic block_t round_fn(block_t s_in, rc_t rc);
    nibble_t s [NumNibbles];
    nibble_t t [NumNibbles];
    nibble_t acc;
    block_t  res;
    for (int i = 0; i < NumNibbles; i++) begin
      s[i] = s_in[63-4*i -: 4];
    end
    for (int r = 0; r < 4; r++) begin
      s[4*r]   = s[4*r] ^ AddConstCol0[r];
      s[4*r+1] = s[4*r+1] ^ ((r % 2 == 0) ? {1'b0, rc[5:3]} : {1'b0, rc[2:0]});
    end
    for (int i = 0; i < NumNibbles; i++) begin
      s[i] = Sbox[s[i]];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[4*r+c] = s[4*r + ((r + c) % 4)];
      end
    end
    res = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(MixMatrix[r][k], t[4*k+c]);
        end
        res[63-4*(4*r+c) -: 4] = acc;
      end
    end
    round_fn = res;
  endfunction

endpackage

@@ hdl/led64_block_encrypt_core.sv @@
// led64 block encrypt core: 33-stage pipeline, initial key add then one round per stage
// the ciphertext is taken from the register of the last round stage
// throughput: one block per cycle when not stalled, set by the one-round-per-stage pipeline
// a downstream stall freezes the whole pipeline; bubbles are not squeezed out
// reset clears all valid bits and the key register to zero; no clearing pass
// depends on led64_pkg, led64_round_stage and the macros header
`include "led64_block_encrypt_core_macros.svh"

module led64_block_encrypt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cipher_key_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] plaintext_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] ciphertext_o
);

  localparam int unsigned NumStages = led64_pkg::NumRounds + 1;

  led64_pkg::block_t key_q;
  led64_pkg::stage_t stg [NumStages];
  logic [NumStages-1:0] vld;
  logic en;
  logic in_valid_q;
  led64_pkg::block_t in_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_q <= cipher_key_i;
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // whitening key add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_data_q <= plaintext_i ^ key_q;
    end
  end

  assign stg[0].valid = in_valid_q;
  assign stg[0].data  = in_data_q;

  for (genvar r = 0; r < led64_pkg::NumRounds; r++) begin : g_round
    led64_round_stage u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .rc_i      (led64_pkg::RoundConst[r]),
      .add_key_i ((r % led64_pkg::RoundsPerKey) == (led64_pkg::RoundsPerKey - 1)),
      .key_i     (key_q),
      .stage_i   (stg[r]),
      .stage_o   (stg[r+1])
    );
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_vld
    assign vld[i] = stg[i].valid;
  end

  assign out_valid_o  = stg[NumStages-1].valid;
  assign ciphertext_o = stg[NumStages-1].data;

  // a stalled output freezes every valid bit in the pipe
  `LED64_ASSERT(a_stall_freezes, (out_valid_o && out_stall_i) |=> $stable(vld))
  // an unstalled cycle shifts the valid bits by one stage
  `LED64_ASSERT(a_shift_valid, en |=> (vld[NumStages-1:1] == $past(vld[NumStages-2:0])))
  // an unstalled cycle loads the first stage from the input valid
  `LED64_ASSERT(a_load_valid, en |=> (vld[0] == $past(in_valid_i)))
  // reset leaves the pipe empty
  `LED64_ASSERT_RST(a_reset_empty, !rst_ni |-> (vld == '0))

endmodule

@@ hdl/led64_round_stage.sv @@
// one registered led64 round, with optional key addition after the round
// depends on led64_pkg
module led64_round_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  led64_pkg::rc_t    rc_i,
  input  logic              add_key_i,
  input  led64_pkg::block_t key_i,
  input  led64_pkg::stage_t stage_i,
  output led64_pkg::stage_t stage_o
);

  logic              valid_q;
  led64_pkg::block_t data_q;
  led64_pkg::block_t data_d;
  led64_pkg::block_t rnd;

  always_comb begin
    rnd    = led64_pkg::round_fn(stage_i.data, rc_i);
    data_d = add_key_i ? (rnd ^ key_i) : rnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule
